// ===== hw/rtl/pbc_pkg.sv =====
// pbc_pkg: shared types, constants and helpers for the power button controller
// no dependencies; imported by pbc_step and power_button_controller
package pbc_pkg;

    localparam int TIME_BITS = 20;
    localparam int CFG_BITS  = 16;

    typedef logic [TIME_BITS-1:0] pbc_time_t;
    typedef logic [CFG_BITS-1:0]  pbc_cfg_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_RELEASE    = 1'b0,
        REG_LONG_PRESS = 1'b1
    } pbc_reg_idx_t;

    localparam pbc_cfg_t RELEASE_RESET    = CFG_BITS'(5000);
    localparam pbc_cfg_t LONG_PRESS_RESET = CFG_BITS'(50000);

    // controller state carried from tick to tick
    typedef struct packed {
        pbc_time_t tick_now;
        logic      power_on_level;
        logic      on_pressed;
        logic      on_released;
        pbc_time_t on_release_stamp;
        logic      off_pressed;
        pbc_time_t off_press_stamp;
        logic      off_released;
        pbc_time_t off_release_stamp;
        logic      off_done;
    } pbc_state_t;

    // one result per tick
    typedef struct packed {
        logic power_enable;
        logic power_on_event;
        logic shutdown_request;
        logic forced_off;
    } pbc_result_t;

    // everything cleared, power enabled
    function automatic pbc_state_t reset_state();
        pbc_state_t s;
        s                = '0;
        s.power_on_level = 1'b1;
        return s;
    endfunction

    localparam pbc_state_t STATE_RESET = reset_state();

    // modular elapsed time strictly above the limit
    function automatic logic exceeds(pbc_time_t earlier, pbc_time_t later, pbc_cfg_t limit);
        pbc_time_t span;
        span = later - earlier;
        return span > TIME_BITS'(limit);
    endfunction

endpackage

// ===== hw/rtl/pbc_step.sv =====
// pbc_step: combinational next-state and result logic for one key tick
// depends on pbc_pkg
module pbc_step
    import pbc_pkg::*;
(
    input  pbc_state_t  state_cur,
    input  logic        key_high,
    input  pbc_cfg_t    release_ticks,
    input  pbc_cfg_t    long_press_ticks,
    output pbc_state_t  state_nxt,
    output pbc_result_t result
);

    always_comb
    begin
        pbc_state_t s;
        pbc_time_t  now;
        logic       ev_on;
        logic       ev_req;
        logic       ev_forced;

        s         = state_cur;
        now       = state_cur.tick_now;
        ev_on     = 1'b0;
        ev_req    = 1'b0;
        ev_forced = 1'b0;

        if ((!s.power_on_level || s.on_pressed) && !s.off_pressed)
        begin
            // power-off side tracker
            if (!s.on_pressed && !key_high)
            begin
                s.on_pressed     = 1'b1;
                s.power_on_level = 1'b1;
                ev_on            = 1'b1;
            end
            if (s.on_pressed && !s.on_released && key_high)
            begin
                s.on_released      = 1'b1;
                s.on_release_stamp = now;
            end
            if (s.on_released)
            begin
                if (exceeds(s.on_release_stamp, now, release_ticks))
                begin
                    s.on_pressed       = 1'b0;
                    s.on_released      = 1'b0;
                    s.on_release_stamp = '0;
                end
                if (!key_high)
                begin
                    s.on_released = 1'b0;
                end
            end
        end
        else if ((s.power_on_level || s.off_pressed) && !s.on_pressed)
        begin
            // power-on side tracker
            if (!s.off_pressed && !key_high)
            begin
                s.off_pressed     = 1'b1;
                s.off_press_stamp = now;
            end
            if (s.off_pressed && !s.off_released && key_high)
            begin
                s.off_released      = 1'b1;
                s.off_release_stamp = now;
            end
            if (s.off_released)
            begin
                if (exceeds(s.off_release_stamp, now, release_ticks))
                begin
                    if (!s.off_done &&
                        exceeds(s.off_press_stamp, s.off_release_stamp, long_press_ticks))
                    begin
                        ev_req = 1'b1;
                    end
                    s.off_pressed       = 1'b0;
                    s.off_press_stamp   = '0;
                    s.off_released      = 1'b0;
                    s.off_release_stamp = '0;
                    s.off_done          = 1'b0;
                end
                if (!key_high)
                begin
                    s.off_released = 1'b0;
                end
            end
            // held press past the long-press limit
            if (s.off_pressed && !s.off_done &&
                exceeds(s.off_press_stamp, now, long_press_ticks))
            begin
                ev_req           = 1'b1;
                ev_forced        = 1'b1;
                s.power_on_level = 1'b0;
                s.off_done       = 1'b1;
            end
        end

        s.tick_now = now + TIME_BITS'(1);

        state_nxt               = s;
        result.power_enable     = s.power_on_level;
        result.power_on_event   = ev_on;
        result.shutdown_request = ev_req;
        result.forced_off       = ev_forced;
    end

endmodule

// ===== hw/rtl/power_button_controller.sv =====
// power_button_controller: top level, tick input register, state and result register
// depends on pbc_pkg and pbc_step
//
// usage
//   input channel: one transfer per 100 us tick, key_level is the sampled power key
//   (0 pressed, 1 released); only its value at the transfer matters
//   output channel: one result transfer per input transfer, in order:
//   power_enable level after the tick plus three one-tick event flags
//   (power_on_event, shutdown_request, forced_off)
//   config port: cfg_we with cfg_index selects release_ticks (0) or
//   long_press_ticks (1); cfg_data is taken at once, write only while idle
// timing
//   a transferred tick sits in the input register; the step logic evaluates it
//   against the tracker state and the result is loaded once the result register
//   is free or being drained, which raises out_valid
//   throughput is one tick per cycle while out_ready stays high: the input
//   register refills on the same edge that moves its tick into the result register
// reset
//   clears both valid flags, tick counter and trackers; the tracked power level
//   resets high and the limits return to 5000 and 50000 ticks
// stall
//   while a result is offered and out_ready is low the result holds, the pending tick
//   waits in the input register and in_ready drops once that register is occupied
module power_button_controller
    import pbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // tick input channel
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         key_level,
    // result channel
    output logic         out_valid,
    input  logic         out_ready,
    output logic         power_enable,
    output logic         power_on_event,
    output logic         shutdown_request,
    output logic         forced_off,
    // configuration write port
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  pbc_cfg_t     cfg_data
);

    // input register
    logic        in_valid_reg;
    logic        key_reg;

    // result register
    logic        out_valid_reg;
    pbc_result_t result_reg;

    // tracker state and limits
    pbc_state_t  state_reg;
    pbc_state_t  state_next;
    pbc_result_t result_next;
    pbc_cfg_t    release_reg;
    pbc_cfg_t    long_press_reg;

    logic        advance;

    // the held tick moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    pbc_step u_step (
        .state_cur        (state_reg),
        .key_high         (key_reg),
        .release_ticks    (release_reg),
        .long_press_ticks (long_press_reg),
        .state_nxt        (state_next),
        .result           (result_next)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg <= key_level;
        end
    end

    // tracker state updates once per tick that reaches the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_reg    <= RELEASE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (pbc_reg_idx_t'(cfg_index))
                REG_RELEASE:    release_reg    <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign power_enable     = result_reg.power_enable;
    assign power_on_event   = result_reg.power_on_event;
    assign shutdown_request = result_reg.shutdown_request;
    assign forced_off       = result_reg.forced_off;

endmodule

// ===== hw/rtl/pbc_checker.sv =====
// pbc_props: port-level assertions for power_button_controller
// depends on nothing but the top level ports; bound to the top level below
module pbc_props (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic power_enable,
    input logic power_on_event,
    input logic shutdown_request,
    input logic forced_off
);

    // a forced shutdown always leaves power dropped and raises a request
    a_forced_drops_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && forced_off |-> !power_enable && shutdown_request)
    else $error("forced_off without dropped power and shutdown request");

    // a power-on event leaves power enabled
    a_on_event_powered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && power_on_event |-> power_enable)
    else $error("power_on_event with power disabled");

    // a tick cannot both switch power on and raise a shutdown request
    a_on_excludes_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && power_on_event |-> !shutdown_request)
    else $error("power_on_event together with shutdown_request");

    // a stalled result stays offered
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_enable))
    else $error("stalled result dropped or changed");

endmodule

bind power_button_controller pbc_props u_pbc_props (.*);
